@@ design/nss_pkg.sv @@
// ----------------------------------------------------------------------------
// nss_pkg
// shared types, codes and constants of the note step sequencer
// ----------------------------------------------------------------------------
package nss_pkg;

	// default table depth
	localparam int MAX_ENTRIES_DEF = 64;

	// field widths
	localparam int KIND_W  = 2;
	localparam int IDX_W   = 6;
	localparam int FREQ_W  = 24;
	localparam int LEN_W   = 16;
	localparam int TPU_W   = 24;
	localparam int ECNT_W  = 7;
	localparam int CNT_W   = 32;
	localparam int THR_W   = TPU_W + LEN_W;
	localparam int FRAC_W  = 16;
	localparam int ENTRY_W = FREQ_W + LEN_W;
	localparam int DCNT_W  = 4;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

	// register indexes (paddr bit 2)
	localparam logic REG_TPU  = 1'b0;
	localparam logic REG_ECNT = 1'b1;

	// register reset values
	localparam logic [TPU_W-1:0]  TPU_RST  = 24'd44100;
	localparam logic [ECNT_W-1:0] ECNT_RST = 7'd1;

	// last divider iteration index (16 quotient bits)
	localparam logic [DCNT_W-1:0] DIV_LAST = 4'd15;

	// microprogram steps
	typedef enum logic [2:0] {
		ST_WAIT,
		ST_INC,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_RDF,
		ST_OUT
	} step_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_INC,
		OP_MUL,
		OP_CMP,
		OP_DIV,
		OP_RDF,
		OP_OUT
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_NO_TICK,
		C_ADVANCE,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	// one control word
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  ret;
	} ctrl_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic tick_acc;
		logic advance;
		logic div_more;
		logic out_busy;
	} status_t;

endpackage

@@ design/nss_ram.sv @@
// ----------------------------------------------------------------------------
// nss_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module nss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/nss_ucode.sv @@
// ----------------------------------------------------------------------------
// nss_ucode
// microprogram rom, step counter and conditional jump logic
// ----------------------------------------------------------------------------
module nss_ucode
	import nss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	step_t step_q;
	step_t step_d;
	logic  jump;

	// control store
	function automatic ctrl_t rom(input step_t s);
		ctrl_t w;
		case (s)
			ST_WAIT: w = '{op: OP_ACCEPT, cond: C_NO_TICK,  target: ST_WAIT, ret: 1'b0};
			ST_INC:  w = '{op: OP_INC,    cond: C_NEVER,    target: ST_WAIT, ret: 1'b0};
			ST_MUL:  w = '{op: OP_MUL,    cond: C_NEVER,    target: ST_WAIT, ret: 1'b0};
			ST_CMP:  w = '{op: OP_CMP,    cond: C_ADVANCE,  target: ST_RDF,  ret: 1'b0};
			ST_DIV:  w = '{op: OP_DIV,    cond: C_DIV_MORE, target: ST_DIV,  ret: 1'b0};
			ST_RDF:  w = '{op: OP_RDF,    cond: C_NEVER,    target: ST_WAIT, ret: 1'b0};
			ST_OUT:  w = '{op: OP_OUT,    cond: C_OUT_BUSY, target: ST_OUT,  ret: 1'b1};
			default: w = '{op: OP_NOP,    cond: C_NEVER,    target: ST_WAIT, ret: 1'b1};
		endcase
		return w;
	endfunction

	// control word of the current step
	always_comb begin
		ctrl = rom(step_q);
	end

	// condition select and next step
	always_comb begin
		case (ctrl.cond)
			C_NEVER:    jump = 1'b0;
			C_NO_TICK:  jump = !status.tick_acc;
			C_ADVANCE:  jump = status.advance;
			C_DIV_MORE: jump = status.div_more;
			C_OUT_BUSY: jump = status.out_busy;
			default:    jump = 1'b0;
		endcase
		if (jump) begin
			step_d = ctrl.target;
		end else if (ctrl.ret) begin
			step_d = ST_WAIT;
		end else begin
			step_d = step_t'(step_q + 3'd1);
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	// divider loop leaves to the frequency read
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_DIV && !status.div_more) |=> (step_q == ST_RDF))
		else $error("divider loop did not exit to frequency read");

endmodule

@@ design/nss_dpath.sv @@
// ----------------------------------------------------------------------------
// nss_dpath
// entry table, tick counter, threshold multiplier, serial divider, output reg
// ----------------------------------------------------------------------------
module nss_dpath
	import nss_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	input  logic [TPU_W-1:0]  tpu,
	input  logic [ECNT_W-1:0] ecnt,
	input  logic              in_acc,
	input  logic [KIND_W-1:0] kind,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [FREQ_W-1:0] entry_frequency,
	input  logic [LEN_W-1:0]  entry_length,
	input  logic              out_stall,
	output status_t           status,
	output logic              out_valid,
	output logic [FREQ_W-1:0] frequency_out,
	output logic [FRAC_W-1:0] position_fraction
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = (AW + 1 > ECNT_W) ? AW + 1 : ECNT_W;

	logic [AW-1:0]     step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [THR_W-1:0]  thr_q;
	logic [THR_W-1:0]  rem_q;
	logic [FRAC_W-1:0] quo_q;
	logic              sat_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              out_valid_q;
	logic [FREQ_W-1:0] freq_out_q;
	logic [FRAC_W-1:0] frac_out_q;

	logic              ram_we;
	logic              ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [FREQ_W-1:0] rd_freq;
	logic [LEN_W-1:0]  rd_len;
	logic [THR_W-1:0]  prod;
	logic [THR_W-1:0]  cnt_shift;
	logic              advance;
	logic [CW-1:0]     step_inc;
	logic [CW-1:0]     ecnt_w;
	logic [CW-1:0]     act_cnt;
	logic [AW-1:0]     step_next;
	logic [THR_W:0]    rem2;
	logic [THR_W:0]    rem_sub;
	logic              rem_ge;
	logic              out_busy;

	// entry table: frequency and length side by side
	assign ram_we = in_acc && (ctrl.op == OP_ACCEPT) && (kind == KIND_WRITE)
		&& (CW'(entry_index) < CW'(MAX_ENTRIES));
	assign ram_re = (ctrl.op == OP_INC) || (ctrl.op == OP_RDF);

	nss_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(entry_index)),
		.wdata ({entry_frequency, entry_length}),
		.re    (ram_re),
		.raddr (step_q),
		.rdata (ram_rdata)
	);

	assign rd_freq = ram_rdata[ENTRY_W-1:LEN_W];
	assign rd_len  = ram_rdata[LEN_W-1:0];

	// step threshold in 1/256 tick
	assign prod = THR_W'(tpu) * THR_W'(rd_len);

	// counter against threshold
	assign cnt_shift = {cnt_q, 8'd0};
	assign advance   = cnt_shift > thr_q;

	// next step index with wrap at the active entry count
	assign ecnt_w   = CW'(ecnt);
	assign step_inc = CW'(step_q) + CW'(1);
	always_comb begin
		if (ecnt_w == '0) begin
			act_cnt = CW'(1);
		end else if (ecnt_w > CW'(MAX_ENTRIES)) begin
			act_cnt = CW'(MAX_ENTRIES);
		end else begin
			act_cnt = ecnt_w;
		end
		if (step_inc >= act_cnt) begin
			step_next = '0;
		end else begin
			step_next = step_inc[AW-1:0];
		end
	end

	// one restoring divide step
	assign rem2    = {rem_q, 1'b0};
	assign rem_sub = rem2 - {1'b0, thr_q};
	assign rem_ge  = rem2 >= {1'b0, thr_q};

	// output register
	assign out_busy = out_valid_q && out_stall;

	// status towards the sequencer
	assign status = '{
		tick_acc: in_acc && (kind == KIND_TICK),
		advance:  advance,
		div_more: dcnt_q != '0,
		out_busy: out_busy
	};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			cnt_q       <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output slot: load a new result or release a taken one
			if ((ctrl.op == OP_OUT) && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (ctrl.op)
				OP_ACCEPT: begin
					if (in_acc && (kind == KIND_RESTART)) begin
						step_q <= '0;
						cnt_q  <= '0;
					end
				end
				OP_INC: begin
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				OP_CMP: begin
					if (advance) begin
						step_q <= step_next;
						cnt_q  <= '0;
					end else begin
						dcnt_q <= DIV_LAST;
					end
				end
				OP_DIV: begin
					if (dcnt_q != '0) begin
						dcnt_q <= dcnt_q - DCNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_MUL: begin
				thr_q <= prod;
			end
			OP_CMP: begin
				quo_q <= '0;
				rem_q <= cnt_shift;
				sat_q <= !advance && (cnt_shift == thr_q);
			end
			OP_DIV: begin
				if (rem_ge) begin
					rem_q <= rem_sub[THR_W-1:0];
					quo_q <= {quo_q[FRAC_W-2:0], 1'b1};
				end else begin
					rem_q <= rem2[THR_W-1:0];
					quo_q <= {quo_q[FRAC_W-2:0], 1'b0};
				end
			end
			OP_OUT: begin
				if (!out_busy) begin
					freq_out_q <= rd_freq;
					frac_out_q <= sat_q ? '1 : quo_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid         = out_valid_q;
	assign frequency_out     = freq_out_q;
	assign position_fraction = frac_out_q;

	// an advance restarts the step count
	a_adv_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_CMP && advance) |=> (cnt_q == '0))
		else $error("counter not cleared on step advance");

	// step index stays inside the table
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(step_q) < CW'(MAX_ENTRIES))
		else $error("step index beyond table depth");

	// exact threshold hit gives a saturated fraction
	a_sat_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_OUT && !out_busy && sat_q) |=> (position_fraction == '1))
		else $error("saturated fraction not presented");

endmodule

@@ design/note_step_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// note_step_sequencer_top
// step sequencer over a table of (frequency, length) entries
// ----------------------------------------------------------------------------
// write and restart requests leave the block in the wait step, ready for
// another request; a sample tick runs the increment, multiply, compare, divide
// (16-bit position fraction), frequency read and output steps, with no divide
// on a step advance; a new tick waits until the last result is in the output register
// reset clears step index, tick counter and the output slot; the entry table
// holds no reset value and must be written before it is played
module note_step_sequencer_top
	import nss_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [FREQ_W-1:0] entry_frequency,
	input  logic [LEN_W-1:0]  entry_length,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [FREQ_W-1:0] frequency_out,
	output logic [FRAC_W-1:0] position_fraction,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [TPU_W-1:0]  tpu_q;
	logic [ECNT_W-1:0] ecnt_q;
	logic              cfg_wr;
	logic              in_acc;
	ctrl_t             ctrl;
	status_t           status;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q  <= TPU_RST;
			ecnt_q <= ECNT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_TPU:  tpu_q  <= pwdata[TPU_W-1:0];
				REG_ECNT: ecnt_q <= pwdata[ECNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[2])
			REG_TPU:  prdata = {{(32 - TPU_W){1'b0}}, tpu_q};
			REG_ECNT: prdata = {{(32 - ECNT_W){1'b0}}, ecnt_q};
			default:  prdata = '0;
		endcase
	end

	// request intake only in the wait step
	assign in_stall = (ctrl.op != OP_ACCEPT);
	assign in_acc   = in_valid && !in_stall;

	nss_ucode u_ucode (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	nss_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.tpu               (tpu_q),
		.ecnt              (ecnt_q),
		.in_acc            (in_acc),
		.kind              (kind),
		.entry_index       (entry_index),
		.entry_frequency   (entry_frequency),
		.entry_length      (entry_length),
		.out_stall         (out_stall),
		.status            (status),
		.out_valid         (out_valid),
		.frequency_out     (frequency_out),
		.position_fraction (position_fraction)
	);

endmodule

@@ dv/note_step_sequencer_top_tb.sv @@
// ----------------------------------------------------------------------------
// note_step_sequencer_top_tb
// drives table writes, restarts and sample ticks into the step sequencer and
// checks every tick result against a cycle-free model of the step logic,
// over a range of register settings, with random idling on both channels
// ----------------------------------------------------------------------------
module note_step_sequencer_top_tb
	import nss_pkg::*;
();

	localparam int ENTRIES        = MAX_ENTRIES_DEF;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 30;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_REQUESTS = 160;

	// kind that the block ignores
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic [FREQ_W-1:0] freq;
		logic [LEN_W-1:0]  len;
	} request_t;

	typedef struct {
		logic [FREQ_W-1:0] freq;
		logic [FRAC_W-1:0] frac;
	} tick_result_t;

	logic              clk             = 1'b0;
	logic              arst_n          = 1'b0;
	logic              in_valid        = 1'b0;
	logic              in_stall;
	logic [KIND_W-1:0] kind            = '0;
	logic [IDX_W-1:0]  entry_index     = '0;
	logic [FREQ_W-1:0] entry_frequency = '0;
	logic [LEN_W-1:0]  entry_length    = '0;
	logic              out_valid;
	logic              out_stall       = 1'b0;
	logic [FREQ_W-1:0] frequency_out;
	logic [FRAC_W-1:0] position_fraction;
	logic              psel            = 1'b0;
	logic              penable         = 1'b0;
	logic              pwrite          = 1'b0;
	logic [2:0]        paddr           = '0;
	logic [31:0]       pwdata          = '0;
	logic [31:0]       prdata;
	logic              pready;

	note_step_sequencer_top u_dut (.*);

	// request and result queues
	request_t     request_q [$];
	tick_result_t tick_result_q [$];

	// model state
	logic [FREQ_W-1:0] freq_tbl [ENTRIES];
	logic [LEN_W-1:0]  len_tbl [ENTRIES];
	int unsigned       play_step  = 0;
	logic [CNT_W-1:0]  tick_count = '0;
	logic [TPU_W-1:0]  tpu_reg    = TPU_RST;
	logic [ECNT_W-1:0] ecnt_reg   = ECNT_RST;

	// generator view of which entries hold data
	bit gen_written [ENTRIES];

	// run bookkeeping
	bit quiet = 1'b0;
	int src_gap = 0;
	int sink_gap = 0;
	int errors = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int step_advances = 0;
	int settings = 0;
	int cycles = 0;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int unsigned active_entries();
		if (ecnt_reg == '0) return 1;
		if (ecnt_reg > ENTRIES) return ENTRIES;
		return ecnt_reg;
	endfunction

	function automatic logic [THR_W-1:0] step_threshold();
		return THR_W'(tpu_reg) * THR_W'(len_tbl[play_step]);
	endfunction

	// model of one accepted request
	function automatic void sequence_request(input request_t rq);
		logic [THR_W-1:0] thr;
		logic [63:0]      quot;
		tick_result_t     res;
		case (rq.kind)
			KIND_WRITE: begin
				freq_tbl[rq.idx] = rq.freq;
				len_tbl[rq.idx]  = rq.len;
			end
			KIND_RESTART: begin
				play_step  = 0;
				tick_count = '0;
			end
			KIND_TICK: begin
				if (tick_count != '1) tick_count++;
				thr = step_threshold();
				// counter past the threshold moves to the next entry
				if ({tick_count, 8'h00} > thr) begin
					play_step  = (play_step + 1 >= active_entries()) ? 0 : play_step + 1;
					tick_count = '0;
					thr        = step_threshold();
					step_advances++;
				end
				if (thr == '0) begin
					quot = '0;
				end else begin
					quot = {8'h00, tick_count, 24'h000000} / 64'(thr);
					if (quot > 64'hFFFF) quot = 64'hFFFF;
				end
				res.freq = freq_tbl[play_step];
				res.frac = quot[FRAC_W-1:0];
				tick_result_q.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// request driver
	always @(posedge clk) begin
		request_t rq;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sequence_request('{kind, entry_index, entry_frequency, entry_length});
				requests_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (request_q.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(1, 12) - 1;
					in_valid <= 1'b0;
				end else if (request_q.size() != 0) begin
					rq = request_q.pop_front();
					kind            <= rq.kind;
					entry_index     <= rq.idx;
					entry_frequency <= rq.freq;
					entry_length    <= rq.len;
					in_valid        <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result stall bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (sink_gap > 0) begin
				sink_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(1, 12) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tick_result_q.size() == 0) begin
				$error("unexpected result: frequency_out %h position_fraction %h",
					frequency_out, position_fraction);
				errors++;
			end else begin
				want = tick_result_q.pop_front();
				results_checked++;
				if (frequency_out !== want.freq) begin
					$error("frequency_out: expected %h, got %h", want.freq, frequency_out);
					errors++;
				end
				if (position_fraction !== want.frac) begin
					$error("position_fraction: expected %h, got %h", want.frac,
						position_fraction);
					errors++;
				end
			end
		end
	end

	// queue one request, tracking table contents
	task automatic add_request(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] i,
		input logic [FREQ_W-1:0] f, input logic [LEN_W-1:0] l);
		request_q.push_back('{k, i, f, l});
		if (k == KIND_WRITE) gen_written[i] = 1'b1;
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return LEN_W'($urandom);
			default: return LEN_W'($urandom_range(1, 1024));
		endcase
	endfunction

	// a tick only once every playable entry holds data
	task automatic add_tick();
		for (int e = 0; e < active_entries(); e++) begin
			if (!gen_written[e]) begin
				add_request(KIND_WRITE, IDX_W'(e), FREQ_W'($urandom), pick_length());
			end
		end
		add_request(KIND_TICK, IDX_W'($urandom), FREQ_W'($urandom), LEN_W'($urandom));
	endtask

	task automatic random_phase(input int count);
		int unsigned pick;
		int unsigned slot;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ENTRIES - 1)
				: $urandom_range(0, active_entries() - 1);
			if (pick < 70) begin
				add_tick();
			end else if (pick < 88) begin
				add_request(KIND_WRITE, IDX_W'(slot), FREQ_W'($urandom), pick_length());
			end else if (pick < 95) begin
				add_request(KIND_RESTART, IDX_W'($urandom), FREQ_W'($urandom),
					LEN_W'($urandom));
			end else begin
				add_request(KIND_SPARE, IDX_W'($urandom), FREQ_W'($urandom),
					LEN_W'($urandom));
			end
		end
	endtask

	// wait for the block to drain, then for any write still in flight
	task automatic wait_idle();
		do @(negedge clk);
		while (request_q.size() != 0 || in_valid || tick_result_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write followed by a read back
	task automatic reg_access(input logic sel, input logic [31:0] wdata,
		input logic [31:0] rmask);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== (wdata & rmask)) begin
			$error("prdata: expected %h, got %h", wdata & rmask, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// new setting, upper bits of the bus filled with noise
	task automatic set_registers(input logic [TPU_W-1:0] tpu, input logic [ECNT_W-1:0] ecnt);
		wait_idle();
		reg_access(REG_TPU, {8'($urandom), tpu}, 32'(TPU_W'('1)));
		tpu_reg = tpu;
		reg_access(REG_ECNT, {25'($urandom), ecnt}, 32'(ECNT_W'('1)));
		ecnt_reg = ecnt;
		settings++;
		@(negedge clk);
	endtask

	// stimulus and end of run
	initial begin
		logic [TPU_W-1:0]  tpu;
		logic [ECNT_W-1:0] ecnt;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: zero threshold, tiny fraction, restart, ignored kind
		add_request(KIND_WRITE, '0, '1, '0);
		add_tick();
		add_tick();
		add_request(KIND_SPARE, '1, '1, '1);
		add_request(KIND_WRITE, '0, 24'h000100, 16'd1);
		add_tick();
		add_tick();
		add_request(KIND_RESTART, '0, '0, '0);
		add_tick();
		add_request(KIND_WRITE, IDX_W'(ENTRIES - 1), '0, '1);
		add_request(KIND_WRITE, IDX_W'(1), 24'h123456, 16'h0100);

		// one tick per length unit: saturated fraction, advance and wrap
		set_registers(24'd1, 7'd2);
		add_tick();
		add_request(KIND_RESTART, '1, '1, '1);
		add_request(KIND_WRITE, '0, 24'h0ABCDE, 16'h0100);
		repeat (4) add_tick();

		// largest threshold, entry count of zero
		set_registers('1, 7'd0);
		add_request(KIND_WRITE, '0, 24'h000001, '1);
		add_tick();
		add_tick();

		// random phases over a spread of settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					tpu  = 24'd1;
					ecnt = '1;
				end
				1: begin
					tpu  = '0;
					ecnt = 7'd64;
				end
				default: begin
					case ($urandom_range(0, 7))
						0: tpu = '0;
						1: tpu = '1;
						2: tpu = TPU_W'($urandom_range(1, 300));
						default: tpu = TPU_W'($urandom_range(1, 6));
					endcase
					case ($urandom_range(0, 5))
						0: ecnt = '0;
						1: ecnt = 7'd1;
						2: ecnt = ECNT_W'($urandom_range(65, 127));
						3: ecnt = 7'd64;
						default: ecnt = ECNT_W'($urandom_range(2, 8));
					endcase
				end
			endcase
			set_registers(tpu, ecnt);
			if (p == RANDOM_PHASES - 1) quiet = 1'b1;
			random_phase(PHASE_REQUESTS);
		end

		wait_idle();
		$display("covered %0d requests and %0d tick results over %0d register settings",
			requests_sent, results_checked, settings);
		$display("steps advanced %0d times", step_advances);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
